// File: design/md5_message_digest_core_defines.svh
// Assertion macros shared by the MD5 digest core files.
// Include guard plus synthesis-empty variants.
`ifndef MD5_MESSAGE_DIGEST_CORE_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MD5_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MD5_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MD5_ASSERT(lbl, clk, rst, prop, msg)
`define MD5_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: design/md5_pkg.sv
// MD5 digest core package: payload types, round constants and helpers.
// Used by every module of the core except md5_ram; no dependencies.
`timescale 1ns / 1ps
package md5_pkg;
   localparam int QueueDepth = 4;
   localparam int BufDepth = 64;

   typedef enum logic [0:0] {REQ_APPEND = 1'b0, REQ_FINISH = 1'b1} req_kind_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word_a;
      logic [31:0] digest_word_b;
      logic [31:0] digest_word_c;
      logic [31:0] digest_word_d;
   } rsp_payload_type;

   // work item from front to back: one byte to store; last marks a finish
   typedef struct packed {
      logic       last;
      logic       wr_byte;
      logic [5:0] addr;
      logic [7:0] data;
      logic       run;
   } work_type;

   localparam logic [31:0] InitA = 32'h67452301;
   localparam logic [31:0] InitB = 32'hefcdab89;
   localparam logic [31:0] InitC = 32'h98badcfe;
   localparam logic [31:0] InitD = 32'h10325476;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
         6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
         6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] round_rot(input logic [5:0] i);
      logic [4:0] r;
      case ({i[5:4], i[1:0]})
         4'd0: r = 5'd7;  4'd1: r = 5'd12; 4'd2: r = 5'd17; 4'd3: r = 5'd22;
         4'd4: r = 5'd5;  4'd5: r = 5'd9;  4'd6: r = 5'd14; 4'd7: r = 5'd20;
         4'd8: r = 5'd4;  4'd9: r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
         4'd12: r = 5'd6; 4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
      endcase
      return r;
   endfunction

   // message word index used by round i
   function automatic logic [3:0] round_g(input logic [5:0] i);
      logic [3:0] g;
      case (i[5:4])
         2'd0: g = i[3:0];
         2'd1: g = 4'(5 * i + 1);
         2'd2: g = 4'(3 * i + 5);
         default: g = 4'(7 * i);
      endcase
      return g;
   endfunction
endpackage

// File: design/md5_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module md5_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: design/md5_front.sv
// Front end: takes requests, expands a finish into padding and length bytes.
// Depends on md5_pkg; feeds the work queue.
`timescale 1ns / 1ps
`include "md5_message_digest_core_defines.svh"
module md5_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  md5_pkg::req_payload_type req_payload,
   output logic                     wk_valid,
   input  logic                     wk_stall,
   output md5_pkg::work_type        wk_item
);
   typedef enum logic [2:0] {
      F_IDLE = 3'b001, F_PAD = 3'b010, F_LEN = 3'b100
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [63:0] count_ff, count_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  pos_ff, pos_in;
   logic        take;

   assign req_stall = (state_ff != F_IDLE) || wk_stall;
   assign take = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      bits_in  = bits_ff;
      pos_in   = pos_ff;
      wk_valid = 1'b0;
      wk_item  = '0;
      case (state_ff)
         F_IDLE: begin
            wk_valid = req_valid;
            wk_item.wr_byte = 1'b1;
            wk_item.addr = count_ff[5:0];
            if (req_payload.req_type == md5_pkg::REQ_FINISH) begin
               wk_item.data = 8'h80;
               wk_item.run  = (count_ff[5:0] == 6'd63);
            end else begin
               wk_item.data = req_payload.data_byte;
               wk_item.run  = (count_ff[5:0] == 6'd63);
            end
            if (take) begin
               if (req_payload.req_type == md5_pkg::REQ_FINISH) begin
                  bits_in  = {count_ff[60:0], 3'b000};
                  pos_in   = count_ff[5:0] + 6'd1;
                  state_in = (count_ff[5:0] == 6'd55) ? F_LEN : F_PAD;
                  count_in = '0;
               end else begin
                  count_in = count_ff + 64'd1;
               end
            end
         end
         F_PAD: begin
            wk_valid = 1'b1;
            wk_item.wr_byte = 1'b1;
            wk_item.addr = pos_ff;
            wk_item.data = 8'h00;
            wk_item.run  = (pos_ff == 6'd63);
            if (!wk_stall) begin
               pos_in = pos_ff + 6'd1;
               if (pos_ff == 6'd55) state_in = F_LEN;
            end
         end
         F_LEN: begin
            wk_valid = 1'b1;
            wk_item.wr_byte = 1'b1;
            wk_item.addr = pos_ff;
            wk_item.data = bits_ff[7:0];
            wk_item.run  = (pos_ff == 6'd63);
            wk_item.last = (pos_ff == 6'd63);
            if (!wk_stall) begin
               pos_in  = pos_ff + 6'd1;
               bits_in = {8'h00, bits_ff[63:8]};
               if (pos_ff == 6'd63) state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      bits_ff <= bits_in;
      pos_ff  <= pos_in;
   end

   `MD5_ASSERT(a_len_from_56, clock, reset,
      (state_ff == F_PAD && !wk_stall && pos_ff == 6'd55) |=> (state_ff == F_LEN && pos_ff == 6'd56),
      "length bytes must start at offset 56")
   `MD5_ASSERT(a_no_take_busy, clock, reset, (state_ff != F_IDLE) |-> !take,
      "request taken while padding")
   `MD5_ASSERT(a_finish_clears, clock, reset,
      (take && req_payload.req_type == md5_pkg::REQ_FINISH) |=> (count_ff == 64'd0),
      "byte count not cleared after finish")
endmodule

// File: design/md5_queue.sv
// Short work queue between the front end and the compression engine.
// Depends on md5_pkg.
`timescale 1ns / 1ps
module md5_queue #(
   parameter int Depth = md5_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  md5_pkg::work_type in_item,
   output logic              out_valid,
   input  logic              out_stall,
   output md5_pkg::work_type out_item
);
   localparam int Aw = $clog2(Depth);
   md5_pkg::work_type slot_ff [Depth];
   logic [Aw-1:0] wp_ff, rp_ff;
   logic [Aw:0]   fill_ff;
   logic push, pop;

   assign in_stall  = (fill_ff == (Aw+1)'(Depth));
   assign out_valid = (fill_ff != '0);
   assign out_item  = slot_ff[rp_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         fill_ff <= fill_ff + (Aw+1)'(push) - (Aw+1)'(pop);
      end
      if (push) slot_ff[wp_ff] <= in_item;
   end
endmodule

// File: design/md5_back.sv
// Back end: writes bytes into the block RAM and runs one MD5 round a cycle.
// Depends on md5_pkg and md5_ram.
`timescale 1ns / 1ps
`include "md5_message_digest_core_defines.svh"
module md5_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wk_valid,
   output logic                     wk_stall,
   input  md5_pkg::work_type        wk_item,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output md5_pkg::rsp_payload_type rsp_payload
);
   typedef enum logic [2:0] {
      B_IDLE = 3'b001, B_ROUND = 3'b010, B_FOLD = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [31:0] ca_ff, cb_ff, cc_ff, cd_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [6:0]  step_ff;
   logic        last_ff, rsp_valid_ff;
   md5_pkg::rsp_payload_type rsp_ff;
   logic [3:0]  ram_rd;
   logic [31:0] word;
   logic [5:0]  rnd;
   logic [31:0] f, t, rot;
   logic [4:0]  s;
   logic        take;
   logic [7:0]  rd0, rd1, rd2, rd3;

   // four byte lanes, addressed by word; lane = addr[1:0]
   for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [7:0] q;
      md5_ram #(.Width(8), .Depth(md5_pkg::BufDepth / 4)) u_ram (
         .clock  (clock),
         .wr_en  (take && wk_item.addr[1:0] == 2'(l)),
         .wr_addr(wk_item.addr[5:2]),
         .wr_data(wk_item.data),
         .rd_addr(ram_rd),
         .rd_data(q)
      );
   end
   assign rd0 = g_lane[0].q;
   assign rd1 = g_lane[1].q;
   assign rd2 = g_lane[2].q;
   assign rd3 = g_lane[3].q;
   assign word = {rd3, rd2, rd1, rd0};

   // step_ff counts prefetch cycle plus 64 rounds; the word for round r is read at step r
   assign rnd = step_ff[5:0] - 6'd1;
   assign ram_rd = md5_pkg::round_g(step_ff[5:0]);

   assign wk_stall = (state_ff != B_IDLE) || rsp_valid_ff;
   assign take = wk_valid && !wk_stall;

   always_comb begin
      case (rnd[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      s = md5_pkg::round_rot(rnd);
      t = a_ff + f + word + md5_pkg::round_k(rnd);
      rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:  if (take && wk_item.run) state_in = B_ROUND;
         B_ROUND: if (step_ff == 7'd64) state_in = B_FOLD;
         B_FOLD:  state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         ca_ff <= md5_pkg::InitA;
         cb_ff <= md5_pkg::InitB;
         cc_ff <= md5_pkg::InitC;
         cd_ff <= md5_pkg::InitD;
         step_ff <= '0;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            B_IDLE: begin
               step_ff <= '0;
               if (take && wk_item.run) begin
                  last_ff <= wk_item.last;
                  step_ff <= 7'd1;
                  a_ff <= ca_ff;
                  b_ff <= cb_ff;
                  c_ff <= cc_ff;
                  d_ff <= cd_ff;
               end
            end
            B_ROUND: begin
               step_ff <= step_ff + 7'd1;
               a_ff <= d_ff;
               d_ff <= c_ff;
               c_ff <= b_ff;
               b_ff <= b_ff + rot;
            end
            B_FOLD: begin
               if (last_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{ca_ff + a_ff, cb_ff + b_ff, cc_ff + c_ff, cd_ff + d_ff};
                  ca_ff <= md5_pkg::InitA;
                  cb_ff <= md5_pkg::InitB;
                  cc_ff <= md5_pkg::InitC;
                  cd_ff <= md5_pkg::InitD;
               end else begin
                  ca_ff <= ca_ff + a_ff;
                  cb_ff <= cb_ff + b_ff;
                  cc_ff <= cc_ff + c_ff;
                  cd_ff <= cd_ff + d_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `MD5_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid,
      "result dropped while stalled")
   `MD5_ASSERT(a_round_len, clock, reset,
      (state_ff == B_FOLD) |-> (step_ff == 7'd65), "compression ran wrong round count")
   `MD5_ASSERT(a_no_take_busy, clock, reset, (state_ff != B_IDLE) |-> !take,
      "byte written during compression")
endmodule

// File: design/md5_message_digest_core.sv
// Top level of the MD5 digest core: front end, work queue, back end.
// Depends on md5_pkg, md5_front, md5_queue, md5_back.
//
// Usage: req_ channel carries one request per transaction: append a byte, or
// finish the message. rsp_ carries one digest per finish, words a..d as MD5
// chaining values (digest bytes little-endian in each word).
// Appends are taken while the work queue has room; the 64th byte of a block
// starts compression, and the single-round engine then takes no further byte
// until it is done (bytes queue ahead meanwhile).
// A finish emits padding and length one byte a cycle while the queue does not
// stall (up to 64 bytes, or up to 72 with an extra block) and then one or two
// compressions; the digest is registered when the last compression folds.
// The round loop in the back end, one MD5 round per cycle, bounds the throughput.
// Reset (synchronous, active high) restores the initial chaining values and
// clears the byte count. A stalled result holds in its output register and
// the back end takes no further work until it is delivered; the queue and
// then req_stall push back on the sender.
`timescale 1ns / 1ps
module md5_message_digest_core #(
   parameter int QueueDepth = md5_pkg::QueueDepth
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  md5_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output md5_pkg::rsp_payload_type rsp_payload
);
   logic fq_valid, fq_stall, qb_valid, qb_stall;
   md5_pkg::work_type fq_item, qb_item;

   md5_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_payload,
      .wk_valid(fq_valid), .wk_stall(fq_stall), .wk_item(fq_item)
   );

   md5_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset,
      .in_valid(fq_valid), .in_stall(fq_stall), .in_item(fq_item),
      .out_valid(qb_valid), .out_stall(qb_stall), .out_item(qb_item)
   );

   md5_back u_back (
      .clock, .reset,
      .wk_valid(qb_valid), .wk_stall(qb_stall), .wk_item(qb_item),
      .rsp_valid, .rsp_stall, .rsp_payload
   );
endmodule
